@@ hdl/sorted_sleep_timer_queue_defines.svh @@
// Assertion macros used by the checker.
`ifndef SORTED_SLEEP_TIMER_QUEUE_DEFINES_SVH
`define SORTED_SLEEP_TIMER_QUEUE_DEFINES_SVH

// Checked at every edge outside reset.
`define SSQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SSQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ssq_pkg.sv @@
`default_nettype none
package ssq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int THREAD_ID_BITS = 8;
    localparam int TIME_BITS      = 32;
    localparam int OCC_BITS       = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_WOKEN    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_TICK
    } ssq_state_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_cmd_t;

endpackage
`default_nettype wire

@@ hdl/sorted_sleep_timer_queue.sv @@
// Sorted sleep timer queue.
// Input channel (s_*): one transfer is a sleep request (s_operation = 0, with
// s_thread_id and s_wake_time) or a timer tick (s_operation = 1).
// Output channel (m_*): result transfers; m_last marks the final result of
// an input transfer. The input is first registered with the state, and the
// first result is then registered in the output register once it is free.
// A sleep request gives one result: accepted, or rejected when all
// QUEUE_DEPTH entries are in use. Equal wake times leave in order of arrival.
// On a tick the counter advances on acceptance, then the head of the cell
// chain is popped one entry a cycle while it is due and the output register
// is free. A tick that wakes nothing gives no result.
// The next input is taken once the previous one has placed its last result
// in the output register, even while that result waits to be taken.
// A stalled receiver holds the output register and pauses the chain,
// delaying the item in progress.
// Reset empties the queue, clears the tick counter and drops any result.
`default_nettype none
module sorted_sleep_timer_queue
    import ssq_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_operation,
    input  wire logic [THREAD_ID_BITS-1:0] s_thread_id,
    input  wire logic [TIME_BITS-1:0]      s_wake_time,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [1:0]                     m_kind,
    output logic [THREAD_ID_BITS-1:0]      m_thread_id_out,
    output logic [TIME_BITS-1:0]           m_wake_time_out,
    output logic                           m_last
);

    ssq_state_t                state_reg, state_next;
    logic [OCC_BITS-1:0]       occ_reg, occ_next;
    logic [TIME_BITS-1:0]      count_reg, count_next;
    logic [THREAD_ID_BITS-1:0] in_tid_reg, in_tid_next;
    logic [TIME_BITS-1:0]      in_time_reg, in_time_next;

    logic                      valid_reg, valid_next;
    kind_t                     kind_reg, kind_next;
    logic [THREAD_ID_BITS-1:0] tid_out_reg, tid_out_next;
    logic [TIME_BITS-1:0]      time_out_reg, time_out_next;
    logic                      last_reg, last_next;

    cell_cmd_t                 cmd;
    logic [THREAD_ID_BITS-1:0] head_tid;
    logic [TIME_BITS-1:0]      head_time, second_time;
    logic                      slot_free, full, head_due, next_due;

    ssq_chain u_chain (
        .aclk        (aclk),
        .cmd         (cmd),
        .occupancy   (occ_reg),
        .new_tid     (in_tid_reg),
        .new_time    (in_time_reg),
        .head_tid    (head_tid),
        .head_time   (head_time),
        .second_time (second_time)
    );

    assign slot_free = !valid_reg || m_ready;
    assign full      = (occ_reg == OCC_BITS'(QUEUE_DEPTH));
    assign head_due  = (occ_reg != '0) && (head_time <= count_reg);
    assign next_due  = (occ_reg > OCC_BITS'(1)) && (second_time <= count_reg);

    always_comb begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        count_next    = count_reg;
        in_tid_next   = in_tid_reg;
        in_time_next  = in_time_reg;
        valid_next    = valid_reg && !m_ready;
        kind_next     = kind_reg;
        tid_out_next  = tid_out_reg;
        time_out_next = time_out_reg;
        last_next     = last_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_tid_next  = s_thread_id;
                    in_time_next = s_wake_time;
                    if (s_operation == OP_TICK) begin
                        count_next = count_reg + 1'b1;
                        state_next = ST_TICK;
                    end else begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                if (slot_free) begin
                    valid_next    = 1'b1;
                    tid_out_next  = in_tid_reg;
                    time_out_next = in_time_reg;
                    last_next     = 1'b1;
                    if (full) begin
                        kind_next = KIND_REJECTED;
                    end else begin
                        kind_next = KIND_ACCEPTED;
                        cmd.ins   = 1'b1;
                        occ_next  = occ_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (!head_due) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    valid_next    = 1'b1;
                    kind_next     = KIND_WOKEN;
                    tid_out_next  = head_tid;
                    time_out_next = head_time;
                    last_next     = !next_due;
                    cmd.pop       = 1'b1;
                    occ_next      = occ_reg - 1'b1;
                    if (!next_due) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_tid_reg   <= in_tid_next;
        in_time_reg  <= in_time_next;
        kind_reg     <= kind_next;
        tid_out_reg  <= tid_out_next;
        time_out_reg <= time_out_next;
        last_reg     <= last_next;
    end

    assign m_valid         = valid_reg;
    assign m_kind          = kind_reg;
    assign m_thread_id_out = tid_out_reg;
    assign m_wake_time_out = time_out_reg;
    assign m_last          = last_reg;

endmodule
`default_nettype wire

@@ hdl/ssq_cell.sv @@
`default_nettype none
module ssq_cell
    import ssq_pkg::*;
(
    input  wire logic                      aclk,
    input  wire cell_cmd_t                 cmd,
    input  wire logic                      in_use,
    input  wire logic [THREAD_ID_BITS-1:0] new_tid,
    input  wire logic [TIME_BITS-1:0]      new_time,
    input  wire logic                      prev_pass,
    input  wire logic [THREAD_ID_BITS-1:0] left_tid,
    input  wire logic [TIME_BITS-1:0]      left_time,
    input  wire logic [THREAD_ID_BITS-1:0] right_tid,
    input  wire logic [TIME_BITS-1:0]      right_time,
    output logic                           pass,
    output logic [THREAD_ID_BITS-1:0]      tid,
    output logic [TIME_BITS-1:0]           wake
);

    logic [THREAD_ID_BITS-1:0] tid_reg, tid_next;
    logic [TIME_BITS-1:0]      time_reg, time_next;

    // entry stays put when it is due no later than the new one
    assign pass = in_use && (time_reg <= new_time);

    always_comb begin
        tid_next  = tid_reg;
        time_next = time_reg;
        if (cmd.pop) begin
            tid_next  = right_tid;
            time_next = right_time;
        end else if (cmd.ins && !pass) begin
            if (prev_pass) begin
                tid_next  = new_tid;
                time_next = new_time;
            end else begin
                tid_next  = left_tid;
                time_next = left_time;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tid_reg  <= tid_next;
        time_reg <= time_next;
    end

    assign tid  = tid_reg;
    assign wake = time_reg;

endmodule
`default_nettype wire

@@ hdl/ssq_chain.sv @@
`default_nettype none
module ssq_chain
    import ssq_pkg::*;
(
    input  wire logic                      aclk,
    input  wire cell_cmd_t                 cmd,
    input  wire logic [OCC_BITS-1:0]       occupancy,
    input  wire logic [THREAD_ID_BITS-1:0] new_tid,
    input  wire logic [TIME_BITS-1:0]      new_time,
    output logic [THREAD_ID_BITS-1:0]      head_tid,
    output logic [TIME_BITS-1:0]           head_time,
    output logic [TIME_BITS-1:0]           second_time
);

    logic [THREAD_ID_BITS-1:0] tid_w  [QUEUE_DEPTH];
    logic [TIME_BITS-1:0]      time_w [QUEUE_DEPTH];
    logic                      pass_w [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                      prev_pass;
        logic [THREAD_ID_BITS-1:0] left_tid, right_tid;
        logic [TIME_BITS-1:0]      left_time, right_time;

        if (i == 0) begin : g_head
            assign prev_pass = 1'b1;
            assign left_tid  = new_tid;
            assign left_time = new_time;
        end else begin : g_body
            assign prev_pass = pass_w[i-1];
            assign left_tid  = tid_w[i-1];
            assign left_time = time_w[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_tid  = tid_w[i];
            assign right_time = time_w[i];
        end else begin : g_inner
            assign right_tid  = tid_w[i+1];
            assign right_time = time_w[i+1];
        end

        ssq_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .in_use     (occupancy > OCC_BITS'(i)),
            .new_tid    (new_tid),
            .new_time   (new_time),
            .prev_pass  (prev_pass),
            .left_tid   (left_tid),
            .left_time  (left_time),
            .right_tid  (right_tid),
            .right_time (right_time),
            .pass       (pass_w[i]),
            .tid        (tid_w[i]),
            .wake       (time_w[i])
        );
    end

    assign head_tid    = tid_w[0];
    assign head_time   = time_w[0];
    assign second_time = time_w[1];

endmodule
`default_nettype wire

@@ hdl/ssq_checker.sv @@
`default_nettype none
`include "sorted_sleep_timer_queue_defines.svh"
module ssq_checker
    import ssq_pkg::*;
(
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      s_operation,
    input wire logic [THREAD_ID_BITS-1:0] s_thread_id,
    input wire logic [TIME_BITS-1:0]      s_wake_time,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [1:0]                m_kind,
    input wire logic [THREAD_ID_BITS-1:0] m_thread_id_out,
    input wire logic [TIME_BITS-1:0]      m_wake_time_out,
    input wire logic                      m_last
);

    `SSQ_ASSERT_ALWAYS(a_reset_drops_result, aclk, !aresetn |=> !m_valid, "result survived reset")

    `SSQ_ASSERT(a_stall_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_thread_id_out) && $stable(m_wake_time_out) && $stable(m_last), "stalled result changed")

    `SSQ_ASSERT(a_kind_legal, aclk, aresetn, m_valid |-> (m_kind == KIND_ACCEPTED || m_kind == KIND_REJECTED || m_kind == KIND_WOKEN), "illegal result kind")

    `SSQ_ASSERT(a_sleep_single, aclk, aresetn, m_valid && m_kind != KIND_WOKEN |-> m_last, "sleep result not marked last")

    `SSQ_ASSERT(a_busy_waking, aclk, aresetn, m_valid && m_kind == KIND_WOKEN && !m_last |-> !s_ready, "input taken while wake-ups pending")

endmodule

bind sorted_sleep_timer_queue ssq_checker u_ssq_checker (.*);
`default_nettype wire
